FILE: sv/fene_pkg.sv
`timescale 1ns / 1ps

package fene_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_K      = 3'd0,
		REG_R0     = 3'd1,
		REG_DRMAX  = 3'd2,
		REG_DRMAX2 = 3'd3,
		REG_INV2   = 3'd4,
		REG_THR    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BROKEN     = 2'd1,
		ST_NODIR      = 2'd2,
		ST_COMPRESSED = 2'd3
	} status_t;

	localparam logic [31:0] K_RST      = 32'd1966080;
	localparam logic [30:0] R0_RST     = 31'd0;
	localparam logic [30:0] DRMAX_RST  = 31'd98304;
	localparam logic [31:0] DRMAX2_RST = 32'd147456;
	localparam logic [31:0] INV2_RST   = 32'd29127;
	localparam logic [15:0] THR_RST    = 16'd1;

	localparam logic [30:0] SAT31   = 31'h7FFF_FFFF;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	typedef struct packed {
		logic signed [31:0] disp_x;
		logic signed [31:0] disp_y;
		logic signed [31:0] disp_z;
	} fene_in_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic [30:0]        bond_energy;
		logic [1:0]         status;
	} fene_out_t;

endpackage

FILE: sv/fene_isqrt.sv
`timescale 1ns / 1ps

module fene_isqrt #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [63:0]       radicand,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [31:0]       root,
	output logic [SIDE_W-1:0] out_side
);
	import fene_pkg::*;

	localparam int STEPS = 32;

	logic              vld_s  [STEPS];
	logic [65:0]       rem_s  [STEPS];
	logic [31:0]       root_s [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int B = STEPS - 1 - k;
		logic              vld_in;
		logic [65:0]       rem_in;
		logic [31:0]       root_in;
		logic [SIDE_W-1:0] side_in;
		logic [65:0]       trial;
		logic              take;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = {2'b00, radicand};
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign trial = (66'(root_in) << (B + 1)) + (66'(1) << (2 * B));
		assign take  = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? rem_in - trial : rem_in;
			root_s[k] <= take ? root_in | (32'(1) << B) : root_in;
			side_s[k] <= side_in;
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign root      = root_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

FILE: sv/fene_div.sv
`timescale 1ns / 1ps

module fene_div #(
	parameter int NUM_W  = 63,
	parameter int DEN_W  = 32,
	parameter int Q_W    = 31,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] out_side
);
	import fene_pkg::*;

	localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic              vld_s  [Q_W];
	logic [W-1:0]      rem_s  [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [Q_W-1:0]    quo_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		localparam int B = Q_W - 1 - k;
		logic              vld_in;
		logic [W-1:0]      rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [Q_W-1:0]    quo_in;
		logic [SIDE_W-1:0] side_in;
		logic [W-1:0]      trial;
		logic              take;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = W'(num);
			assign den_in  = den;
			assign quo_in  = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign trial = W'(den_in) << B;
		assign take  = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? rem_in - trial : rem_in;
			quo_s[k]  <= take ? quo_in | (Q_W'(1) << B) : quo_in;
			den_s[k]  <= den_in;
			side_s[k] <= side_in;
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign quo       = quo_s[Q_W-1];
	assign out_side  = side_s[Q_W-1];

endmodule

FILE: sv/fene_nlog.sv
`timescale 1ns / 1ps

module fene_nlog #(
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 1,
	localparam int PW       = $clog2(FRAC_BITS + 1),
	localparam int NL_W     = FRAC_BITS + PW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [FRAC_BITS:0] q,
	input  logic [SIDE_W-1:0]  in_side,
	output logic               out_valid,
	output logic [NL_W-1:0]    neg_ln,
	output logic [SIDE_W-1:0]  out_side
);
	import fene_pkg::*;

	localparam int F = FRAC_BITS;

	logic [PW-1:0]     p0;
	logic [2*F:0]      wide0;

	logic              vld_s  [F+1];
	logic [F:0]        m_s    [F+1];
	logic [F-1:0]      frac_s [F+1];
	logic [PW-1:0]     p_s    [F+1];
	logic [SIDE_W-1:0] side_s [F+1];

	logic [NL_W-1:0]    nl;
	logic [NL_W+31:0]   lp;
	logic               vld_q;
	logic [NL_W-1:0]    res_q;
	logic [SIDE_W-1:0]  side_q;

	// leading one of q
	always_comb begin
		p0 = '0;
		for (int i = 0; i <= F; i++) begin
			if (q[i]) begin
				p0 = PW'(i);
			end
		end
	end

	assign wide0 = {q, {F{1'b0}}} >> p0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		m_s[0]    <= wide0[F:0];
		frac_s[0] <= '0;
		p_s[0]    <= p0;
		side_s[0] <= in_side;
	end

	for (genvar j = 1; j <= F; j++) begin : g_sq
		logic [2*F+1:0] sq;
		logic [F+1:0]   t;

		assign sq = m_s[j-1] * m_s[j-1];
		assign t  = sq[2*F+1:F];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			m_s[j]    <= t[F+1] ? t[F+1:1] : t[F:0];
			frac_s[j] <= t[F+1] ? frac_s[j-1] | (F'(1) << (F - j)) : frac_s[j-1];
			p_s[j]    <= p_s[j-1];
			side_s[j] <= side_s[j-1];
		end
	end

	assign nl = {PW'(F) - p_s[F], {F{1'b0}}} - NL_W'(frac_s[F]);
	assign lp = nl * LN2_Q32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s[F];
		end
	end

	always_ff @(posedge clk) begin
		res_q  <= lp[NL_W+31:32];
		side_q <= side_s[F];
	end

	assign out_valid = vld_q;
	assign neg_ln    = res_q;
	assign out_side  = side_q;

endmodule

FILE: sv/fene_bond_force_energy.sv
`timescale 1ns / 1ps
// FENE bond force and energy, fully pipelined (Q16.16 at FRAC_BITS = 16).
// The path runs through the 32-step square root, the log pipeline, a 31-step magnitude
// quotient pipeline and three parallel 31-step component quotient pipelines.
// Throughput: one word per cycle; busy stays low and results cannot be stalled.
// Reset clears all valid bits and loads the register defaults.

module fene_bond_force_energy #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  fene_pkg::fene_in_t             item,
	output logic                           done,
	output fene_pkg::fene_out_t            result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fene_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import fene_pkg::*;

	localparam int F    = FRAC_BITS;
	localparam int NL_W = F + $clog2(F + 1);
	localparam int EP_W = 64 + NL_W;
	localparam int LAT  = 108 + F;

	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][31:0] mag;
	} geo_t;

	typedef struct packed {
		geo_t        geo;
		logic [31:0] len;
		logic [30:0] adr;
		logic        dr_pos;
		logic [1:0]  status;
		logic        kill;
	} item_t;

	typedef struct packed {
		item_t       itm;
		logic [62:0] kadr;
		logic [F:0]  q;
	} mid_t;

	typedef struct packed {
		item_t       itm;
		logic [30:0] energy;
		logic        ovf;
	} tail_t;

	logic [31:0] k_q, drmax2_q, inv2_q;
	logic [30:0] r0_q, drmax_q;
	logic [15:0] thr_q;
	logic [63:0] kd2_q;

	logic              accept;
	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic              vld_e1, vld_e2, vld_m1, vld_o;
	geo_t              geo_s1, geo_s2, geo_s3;
	logic [2:0][63:0]  sq_s2;
	logic [63:0]       len2_s3;

	logic              sq_vld;
	logic [31:0]       len;
	geo_t              geo_sq;

	logic signed [33:0] dr;
	logic signed [33:0] drmax_x;
	logic [33:0]        adr_full;
	logic               broken, comp, near_zero, nodir;
	logic [1:0]         st;

	item_t       itm_s4, itm_s5, itm_s6, itm_s7, itm_s8;
	logic [61:0] adr2_s5;
	logic [63:0] plo_s6;
	logic [61:0] phi_s6;
	logic [62:0] kadr_s6, kadr_s7, kadr_s8;
	logic [93:0] prod_s7;
	logic [F:0]  q_s8;

	logic            nl_vld;
	logic [NL_W-1:0] nl;
	mid_t            mid_nl, mid_e1, mid_e2;
	logic [NL_W+31:0] elo_e1, ehi_e1;
	logic            ovf_e1, ovf_e2;
	logic [EP_W-1:0] ep;
	logic [30:0]     energy_e2;
	tail_t           tail_e2, tail_md, tail_m1, tail_cd;

	logic             md_vld;
	logic [30:0]      md_quo;
	logic [30:0]      mag;
	logic [2:0][62:0] cp_m1;
	logic             cd_vld;
	logic [2:0][30:0] cq;

	fene_out_t res_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= K_RST;
			r0_q     <= R0_RST;
			drmax_q  <= DRMAX_RST;
			drmax2_q <= DRMAX2_RST;
			inv2_q   <= INV2_RST;
			thr_q    <= THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_K:      k_q      <= cfg_data;
				REG_R0:     r0_q     <= cfg_data[30:0];
				REG_DRMAX:  drmax_q  <= cfg_data[30:0];
				REG_DRMAX2: drmax2_q <= cfg_data;
				REG_INV2:   inv2_q   <= cfg_data;
				REG_THR:    thr_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		kd2_q <= k_q * drmax2_q;
	end

	// valid chain outside the sub-pipelines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_e1 <= 1'b0;
			vld_e2 <= 1'b0;
			vld_m1 <= 1'b0;
			vld_o  <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= sq_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_e1 <= nl_vld;
			vld_e2 <= vld_e1;
			vld_m1 <= md_vld;
			vld_o  <= cd_vld;
		end
	end

	// magnitudes, squares, squared length
	always_ff @(posedge clk) begin
		geo_s1.neg    <= {item.disp_z[31], item.disp_y[31], item.disp_x[31]};
		geo_s1.mag[0] <= item.disp_x[31] ? 32'(-item.disp_x) : 32'(item.disp_x);
		geo_s1.mag[1] <= item.disp_y[31] ? 32'(-item.disp_y) : 32'(item.disp_y);
		geo_s1.mag[2] <= item.disp_z[31] ? 32'(-item.disp_z) : 32'(item.disp_z);
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= geo_s1.mag[i] * geo_s1.mag[i];
		end
		geo_s2  <= geo_s1;
		len2_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		geo_s3  <= geo_s2;
	end

	fene_isqrt #(
		.SIDE_W ($bits(geo_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.radicand  (len2_s3),
		.in_side   (geo_s3),
		.out_valid (sq_vld),
		.root      (len),
		.out_side  (geo_sq)
	);

	// stretch and case split
	assign dr        = $signed({2'b00, len}) - $signed({3'b000, r0_q});
	assign drmax_x   = $signed({3'b000, drmax_q});
	assign broken    = dr >= drmax_x;
	assign comp      = dr <= -drmax_x;
	assign adr_full  = dr[33] ? 34'(-dr) : 34'(dr);
	assign near_zero = adr_full <= 34'(thr_q);
	assign nodir     = len <= 32'(thr_q);

	always_comb begin
		if (broken) begin
			st = ST_BROKEN;
		end else if (comp) begin
			st = ST_COMPRESSED;
		end else if (!near_zero && nodir) begin
			st = ST_NODIR;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		itm_s4.geo    <= geo_sq;
		itm_s4.len    <= len;
		itm_s4.adr    <= adr_full[30:0];
		itm_s4.dr_pos <= !dr[33] && (dr != '0);
		itm_s4.status <= st;
		itm_s4.kill   <= broken || comp || near_zero || nodir;

		adr2_s5 <= itm_s4.adr * itm_s4.adr;
		itm_s5  <= itm_s4;

		plo_s6  <= adr2_s5[31:0] * inv2_q;
		phi_s6  <= adr2_s5[61:32] * inv2_q;
		kadr_s6 <= k_q * itm_s5.adr;
		itm_s6  <= itm_s5;

		prod_s7 <= (94'(phi_s6) << 32) + 94'(plo_s6);
		kadr_s7 <= kadr_s6;
		itm_s7  <= itm_s6;

		// 1 - rho, clamped to one lsb
		q_s8    <= (|prod_s7[93:3*F]) ? (F+1)'(1)
		           : {1'b1, {F{1'b0}}} - {1'b0, prod_s7[3*F-1:2*F]};
		kadr_s8 <= kadr_s7;
		itm_s8  <= itm_s7;
	end

	fene_nlog #(
		.FRAC_BITS (F),
		.SIDE_W    ($bits(mid_t))
	) u_nlog (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s8),
		.q         (q_s8),
		.in_side   ({itm_s8, kadr_s8, q_s8}),
		.out_valid (nl_vld),
		.neg_ln    (nl),
		.out_side  (mid_nl)
	);

	// energy product
	assign ep = (EP_W'(ehi_e1) << 32) + EP_W'(elo_e1);

	always_ff @(posedge clk) begin
		elo_e1 <= kd2_q[31:0] * nl;
		ehi_e1 <= kd2_q[63:32] * nl;
		ovf_e1 <= mid_nl.kadr >= (63'(mid_nl.q) << 31);
		mid_e1 <= mid_nl;

		energy_e2 <= (|ep[EP_W-1:2*F+32]) ? SAT31 : ep[2*F+31:2*F+1];
		ovf_e2    <= ovf_e1;
		mid_e2    <= mid_e1;
	end

	assign tail_e2.itm    = mid_e2.itm;
	assign tail_e2.energy = energy_e2;
	assign tail_e2.ovf    = ovf_e2;

	fene_div #(
		.NUM_W  (63),
		.DEN_W  (F + 1),
		.Q_W    (31),
		.SIDE_W ($bits(tail_t))
	) u_div_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_e2),
		.num       (mid_e2.kadr),
		.den       (mid_e2.q),
		.in_side   (tail_e2),
		.out_valid (md_vld),
		.quo       (md_quo),
		.out_side  (tail_md)
	);

	assign mag = tail_md.ovf ? SAT31 : md_quo;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cp_m1[i] <= mag * tail_md.itm.geo.mag[i];
		end
		tail_m1 <= tail_md;
	end

	fene_div #(
		.NUM_W  (63),
		.DEN_W  (32),
		.Q_W    (31),
		.SIDE_W ($bits(tail_t))
	) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_m1),
		.num       (cp_m1[0]),
		.den       (tail_m1.itm.len),
		.in_side   (tail_m1),
		.out_valid (cd_vld),
		.quo       (cq[0]),
		.out_side  (tail_cd)
	);

	fene_div #(
		.NUM_W  (63),
		.DEN_W  (32),
		.Q_W    (31),
		.SIDE_W (1)
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_m1),
		.num       (cp_m1[1]),
		.den       (tail_m1.itm.len),
		.in_side   (1'b0),
		.out_valid (),
		.quo       (cq[1]),
		.out_side  ()
	);

	fene_div #(
		.NUM_W  (63),
		.DEN_W  (32),
		.Q_W    (31),
		.SIDE_W (1)
	) u_div_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_m1),
		.num       (cp_m1[2]),
		.den       (tail_m1.itm.len),
		.in_side   (1'b0),
		.out_valid (),
		.quo       (cq[2]),
		.out_side  ()
	);

	// signs, case overrides, output word
	always_ff @(posedge clk) begin
		logic [2:0][31:0] fv;
		for (int i = 0; i < 3; i++) begin
			if (tail_cd.itm.kill) begin
				fv[i] = '0;
			end else if (tail_cd.itm.dr_pos != tail_cd.itm.geo.neg[i]) begin
				fv[i] = 32'(-{1'b0, cq[i]});
			end else begin
				fv[i] = {1'b0, cq[i]};
			end
		end
		res_q.force_x <= fv[0];
		res_q.force_y <= fv[1];
		res_q.force_z <= fv[2];
		res_q.status  <= tail_cd.itm.status;
		case (tail_cd.itm.status)
			ST_BROKEN:     res_q.bond_energy <= '0;
			ST_COMPRESSED: res_q.bond_energy <= SAT31;
			default:       res_q.bond_energy <= tail_cd.energy;
		endcase
	end

	assign done   = vld_o;
	assign result = res_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("accepted word did not complete after fixed latency");

	a_broken: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_BROKEN |->
			result.bond_energy == '0 && result.force_x == '0 &&
			result.force_y == '0 && result.force_z == '0)
		else $error("broken bond with nonzero output");

	a_compressed: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_COMPRESSED |->
			result.bond_energy == SAT31 && result.force_x == '0 &&
			result.force_y == '0 && result.force_z == '0)
		else $error("over-compressed bond output wrong");

	a_nodir: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_NODIR |->
			result.force_x == '0 && result.force_y == '0 && result.force_z == '0)
		else $error("undefined direction with nonzero force");

endmodule
